### src/minimum_jerk_trajectory_macros.svh
`ifndef MINIMUM_JERK_TRAJECTORY_MACROS_SVH
`define MINIMUM_JERK_TRAJECTORY_MACROS_SVH

// Same-cycle implication, off during reset.
`define MJT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("minimum jerk trajectory check failed");

// Next-cycle implication, off during reset.
`define MJT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("minimum jerk trajectory check failed");

// Same-cycle implication that also holds across reset.
`define MJT_ASSERT_PLAIN(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("minimum jerk trajectory check failed");

`endif

### src/mjt_pkg.sv
`timescale 1ns / 1ps

package mjt_pkg;

   localparam int MAX_STEPS = 64;
   localparam int FRAC_BITS = 16;
   localparam int CNT_W     = 7;
   localparam int TS_W      = 16;
   localparam int CSR_W     = TS_W;
   // 64 * 65535 stays below 2**22
   localparam int TR_W      = 22;
   // 64**5 == 2**30
   localparam int NP_W      = 31;
   localparam int WIDE_W    = 128;
   localparam int Q_W       = 32;
   localparam int DIV_W     = NP_W + Q_W - 1;
   localparam int SH_W      = WIDE_W - (2 * FRAC_BITS + 1);
   localparam int NCOEF     = 6;

   localparam logic [CNT_W-1:0] STEP_COUNT_RESET = 7'd50;
   localparam logic [TS_W-1:0]  TIME_STEP_RESET  = 16'd1311;

   localparam logic [Q_W-1:0] SAT_HI = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] SAT_LO = 32'h8000_0000;
   localparam logic [Q_W-1:0] BIAS   = 32'h8000_0000;

   typedef enum logic [0:0] {
      CSR_STEP_COUNT = 1'b0,
      CSR_TIME_STEP  = 1'b1
   } csr_index_type;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic signed [31:0] start_position;
      logic signed [31:0] start_velocity;
      logic signed [31:0] start_accel;
      logic signed [31:0] end_position;
      logic signed [31:0] end_velocity;
      logic signed [31:0] end_accel;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic [CNT_W-1:0]   sample_index;
      logic               last_sample;
   } rsp_type;

   // term[i] is coefficient i scaled by N**(5-i)
   typedef struct packed {
      logic [NCOEF-1:0][WIDE_W-1:0] term;
      logic [NP_W-1:0]              npow;
      logic [CNT_W-1:0]             count;
   } coef_type;

endpackage

### src/mjt_coef.sv
`timescale 1ns / 1ps

module mjt_coef (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  mjt_pkg::req_type          in_data,
   input  logic [mjt_pkg::CNT_W-1:0] count,
   input  logic [mjt_pkg::TS_W-1:0]  tstep,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mjt_pkg::coef_type         out_data
);

   localparam int SCALE = mjt_pkg::NCOEF - 1;
   localparam int NS    = 7 + SCALE;
   localparam int M1_W  = 32 + mjt_pkg::TR_W + 1;
   localparam int M2_W  = M1_W + mjt_pkg::TR_W + 1;
   localparam int N2_W  = 13;
   localparam int N4_W  = 25;

   logic [NS-1:0] v_ff;
   logic          adv;

   assign adv       = !v_ff[NS-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   // stage 1: capture, total time in time_step units
   logic signed [31:0]          sp1_ff, sv1_ff, sa1_ff, ep1_ff, ev1_ff, ea1_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt1_ff;
   logic [mjt_pkg::TR_W-1:0]    tr1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sp1_ff  <= in_data.start_position;
         sv1_ff  <= in_data.start_velocity;
         sa1_ff  <= in_data.start_accel;
         ep1_ff  <= in_data.end_position;
         ev1_ff  <= in_data.end_velocity;
         ea1_ff  <= in_data.end_accel;
         cnt1_ff <= count;
         tr1_ff  <= mjt_pkg::TR_W'(count) * mjt_pkg::TR_W'(tstep);
      end
   end

   // stage 2: first products by T
   logic signed [M1_W-1:0]      msv2_in, msa2_in, mev2_in, mea2_in;
   logic signed [M1_W-1:0]      msv2_ff, msa2_ff, mev2_ff, mea2_ff;
   logic signed [31:0]          sp2_ff, ep2_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt2_ff;
   logic [mjt_pkg::TR_W-1:0]    tr2_ff;
   logic [N2_W-1:0]             nsq2_ff;

   assign msv2_in = sv1_ff * $signed({1'b0, tr1_ff});
   assign msa2_in = sa1_ff * $signed({1'b0, tr1_ff});
   assign mev2_in = ev1_ff * $signed({1'b0, tr1_ff});
   assign mea2_in = ea1_ff * $signed({1'b0, tr1_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         msv2_ff <= msv2_in;
         msa2_ff <= msa2_in;
         mev2_ff <= mev2_in;
         mea2_ff <= mea2_in;
         sp2_ff  <= sp1_ff;
         ep2_ff  <= ep1_ff;
         cnt2_ff <= cnt1_ff;
         tr2_ff  <= tr1_ff;
         nsq2_ff <= N2_W'(cnt1_ff) * N2_W'(cnt1_ff);
      end
   end

   // stage 3: boundary terms scaled to a common 2^(2F) base
   logic signed [M2_W-1:0]      k2_in, l2_in;
   mjt_pkg::wide_type           sp_w, ep_w, sv_w, ev_w;
   mjt_pkg::wide_type           k0_3_ff, k1_3_ff, k2_3_ff, l0_3_ff, l1_3_ff, l2_3_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt3_ff;
   logic [N4_W-1:0]             nq3_ff;

   assign k2_in = msa2_ff * $signed({1'b0, tr2_ff});
   assign l2_in = mea2_ff * $signed({1'b0, tr2_ff});
   assign sp_w  = mjt_pkg::WIDE_W'(sp2_ff);
   assign ep_w  = mjt_pkg::WIDE_W'(ep2_ff);
   assign sv_w  = mjt_pkg::WIDE_W'(msv2_ff);
   assign ev_w  = mjt_pkg::WIDE_W'(mev2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         k0_3_ff <= sp_w << (2 * mjt_pkg::FRAC_BITS);
         l0_3_ff <= ep_w << (2 * mjt_pkg::FRAC_BITS);
         k1_3_ff <= sv_w << mjt_pkg::FRAC_BITS;
         l1_3_ff <= ev_w << mjt_pkg::FRAC_BITS;
         k2_3_ff <= mjt_pkg::WIDE_W'(k2_in);
         l2_3_ff <= mjt_pkg::WIDE_W'(l2_in);
         cnt3_ff <= cnt2_ff;
         nq3_ff  <= N4_W'(nsq2_ff) * N4_W'(nsq2_ff);
      end
   end

   // stage 4: boundary differences
   mjt_pkg::wide_type           p4_ff, q4_ff, b1_4_ff, b2_4_ff, c0_4_ff, c1_4_ff, c2_4_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt4_ff;
   logic [mjt_pkg::NP_W-1:0]    np4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_ff   <= (l0_3_ff << 1) - (k0_3_ff << 1);
         q4_ff   <= (k1_3_ff << 1) + k2_3_ff;
         b1_4_ff <= l1_3_ff - k1_3_ff - k2_3_ff;
         b2_4_ff <= l2_3_ff - k2_3_ff;
         c0_4_ff <= k0_3_ff << 1;
         c1_4_ff <= k1_3_ff << 1;
         c2_4_ff <= k2_3_ff;
         cnt4_ff <= cnt3_ff;
         np4_ff  <= mjt_pkg::NP_W'(nq3_ff) * mjt_pkg::NP_W'(cnt3_ff);
      end
   end

   // stage 5
   mjt_pkg::wide_type           b0_5_ff, b1_5_ff, b2_5_ff, c0_5_ff, c1_5_ff, c2_5_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt5_ff;
   logic [mjt_pkg::NP_W-1:0]    np5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_5_ff <= p4_ff - q4_ff;
         b1_5_ff <= b1_4_ff;
         b2_5_ff <= b2_4_ff;
         c0_5_ff <= c0_4_ff;
         c1_5_ff <= c1_4_ff;
         c2_5_ff <= c2_4_ff;
         cnt5_ff <= cnt4_ff;
         np5_ff  <= np4_ff;
      end
   end

   // stage 6: closed-form inverse, first half
   mjt_pkg::wide_type           u3_6_ff, u4_6_ff, u5_6_ff, b2_6_ff, c0_6_ff, c1_6_ff, c2_6_ff;
   logic [mjt_pkg::CNT_W-1:0]   cnt6_ff;
   logic [mjt_pkg::NP_W-1:0]    np6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u3_6_ff <= b0_5_ff * 10 - (b1_5_ff << 3);
         u4_6_ff <= b1_5_ff * 14 - b0_5_ff * 15;
         u5_6_ff <= b0_5_ff * 6 - b1_5_ff * 6;
         b2_6_ff <= b2_5_ff;
         c0_6_ff <= c0_5_ff;
         c1_6_ff <= c1_5_ff;
         c2_6_ff <= c2_5_ff;
         cnt6_ff <= cnt5_ff;
         np6_ff  <= np5_ff;
      end
   end

   // stage 7 fills scale slot 0; slots 1..5 multiply the low terms by N
   logic [mjt_pkg::NCOEF-1:0][mjt_pkg::WIDE_W-1:0] sc_ff [0:SCALE];
   logic [mjt_pkg::CNT_W-1:0]                      sn_ff [0:SCALE];
   logic [mjt_pkg::NP_W-1:0]                       snp_ff [0:SCALE];

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff[0][0] <= c0_6_ff;
         sc_ff[0][1] <= c1_6_ff;
         sc_ff[0][2] <= c2_6_ff;
         sc_ff[0][3] <= u3_6_ff + b2_6_ff;
         sc_ff[0][4] <= u4_6_ff - (b2_6_ff << 1);
         sc_ff[0][5] <= u5_6_ff + b2_6_ff;
         sn_ff[0]    <= cnt6_ff;
         snp_ff[0]   <= np6_ff;
      end
   end

   for (genvar s = 0; s < SCALE; s++) begin : g_scale
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < mjt_pkg::NCOEF; i++) begin
               if (i < SCALE - s) begin
                  sc_ff[s+1][i] <= sc_ff[s][i] * mjt_pkg::WIDE_W'(sn_ff[s]);
               end else begin
                  sc_ff[s+1][i] <= sc_ff[s][i];
               end
            end
            sn_ff[s+1]  <= sn_ff[s];
            snp_ff[s+1] <= snp_ff[s];
         end
      end
   end

   assign out_data.term  = sc_ff[SCALE];
   assign out_data.npow  = snp_ff[SCALE];
   assign out_data.count = sn_ff[SCALE];

endmodule

### src/mjt_sample.sv
`timescale 1ns / 1ps

module mjt_sample (
   input  logic              clock,
   input  logic              reset,
   input  logic              coef_valid,
   output logic              coef_ready,
   input  mjt_pkg::coef_type coef,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mjt_pkg::rsp_type  rsp_data
);

   localparam int HORNER = mjt_pkg::NCOEF - 1;
   localparam int QW     = mjt_pkg::Q_W;

   logic                      adv;
   logic                      out_v_ff;
   mjt_pkg::rsp_type          out_ff;

   assign adv = !out_v_ff || rsp_ready;

   // run bank and sample counter
   mjt_pkg::coef_type         bank_ff;
   logic                      busy_ff;
   logic [mjt_pkg::CNT_W-1:0] k_ff;
   logic [HORNER-1:0]         hv_ff;
   logic                      load, issue;

   assign coef_ready = !busy_ff && (hv_ff == '0);
   assign load       = coef_valid && coef_ready;
   assign issue      = busy_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         k_ff    <= mjt_pkg::CNT_W'(1);
      end else if (issue) begin
         k_ff <= k_ff + mjt_pkg::CNT_W'(1);
         if (k_ff == bank_ff.count) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff <= coef;
      end
   end

   // Horner steps over k, one per stage
   logic [mjt_pkg::WIDE_W-1:0] h_ff  [0:HORNER-1];
   logic [mjt_pkg::CNT_W-1:0]  hk_ff [0:HORNER-1];
   logic                       hl_ff [0:HORNER-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= '0;
      end else if (adv) begin
         hv_ff <= {hv_ff[HORNER-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff[0]  <= bank_ff.term[HORNER] * mjt_pkg::WIDE_W'(k_ff) + bank_ff.term[HORNER-1];
         hk_ff[0] <= k_ff;
         hl_ff[0] <= (k_ff == bank_ff.count);
      end
   end

   for (genvar j = 1; j < HORNER; j++) begin : g_horner
      always_ff @(posedge clock) begin
         if (adv) begin
            h_ff[j]  <= h_ff[j-1] * mjt_pkg::WIDE_W'(hk_ff[j-1])
                        + bank_ff.term[HORNER-1-j];
            hk_ff[j] <= hk_ff[j-1];
            hl_ff[j] <= hl_ff[j-1];
         end
      end
   end

   // round half up, then bias by 2^31 quotients so the divide is unsigned
   logic [mjt_pkg::WIDE_W-1:0] off_c, sum_c;
   logic [mjt_pkg::SH_W-1:0]   ry_ff;
   logic [mjt_pkg::NP_W-1:0]   rnp_ff;
   logic [mjt_pkg::CNT_W-1:0]  rk_ff;
   logic                       rl_ff, rv_ff;

   assign off_c = (mjt_pkg::WIDE_W'(bank_ff.npow) << (2 * mjt_pkg::FRAC_BITS))
                + (mjt_pkg::WIDE_W'(bank_ff.npow) << (2 * mjt_pkg::FRAC_BITS + QW));
   assign sum_c = h_ff[HORNER-1] + off_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (adv) begin
         rv_ff <= hv_ff[HORNER-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ry_ff  <= sum_c[mjt_pkg::WIDE_W-1:2*mjt_pkg::FRAC_BITS+1];
         rnp_ff <= bank_ff.npow;
         rk_ff  <= hk_ff[HORNER-1];
         rl_ff  <= hl_ff[HORNER-1];
      end
   end

   // range check, then one quotient bit per stage
   logic [mjt_pkg::DIV_W-1:0]  rem_ff [0:QW];
   logic [QW-1:0]              q_ff   [0:QW];
   logic [mjt_pkg::NP_W-1:0]   dnp_ff [0:QW];
   logic [mjt_pkg::CNT_W-1:0]  dk_ff  [0:QW];
   logic                       dl_ff  [0:QW];
   logic                       slo_ff [0:QW];
   logic                       shi_ff [0:QW];
   logic                       dv_ff  [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= ry_ff[mjt_pkg::DIV_W-1:0];
         q_ff[0]   <= '0;
         dnp_ff[0] <= rnp_ff;
         dk_ff[0]  <= rk_ff;
         dl_ff[0]  <= rl_ff;
         slo_ff[0] <= ry_ff[mjt_pkg::SH_W-1];
         shi_ff[0] <= !ry_ff[mjt_pkg::SH_W-1] && (ry_ff >= {rnp_ff, {QW{1'b0}}});
      end
   end

   for (genvar d = 0; d < QW; d++) begin : g_div
      logic [mjt_pkg::DIV_W-1:0] trial;
      logic                      ge;

      assign trial = mjt_pkg::DIV_W'(dnp_ff[d]) << (QW - 1 - d);
      assign ge    = rem_ff[d] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[d+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[d+1] <= dv_ff[d];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[d+1] <= ge ? rem_ff[d] - trial : rem_ff[d];
            q_ff[d+1]   <= {q_ff[d][QW-2:0], ge};
            dnp_ff[d+1] <= dnp_ff[d];
            dk_ff[d+1]  <= dk_ff[d];
            dl_ff[d+1]  <= dl_ff[d];
            slo_ff[d+1] <= slo_ff[d];
            shi_ff[d+1] <= shi_ff[d];
         end
      end
   end

   // output register; holds while the receiver stalls
   logic [QW-1:0] value_c;

   always_comb begin
      if (slo_ff[QW]) begin
         value_c = mjt_pkg::SAT_LO;
      end else if (shi_ff[QW]) begin
         value_c = mjt_pkg::SAT_HI;
      end else begin
         value_c = q_ff[QW] ^ mjt_pkg::BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.sample_value <= value_c;
         out_ff.sample_index <= dk_ff[QW];
         out_ff.last_sample  <= dl_ff[QW];
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

### src/minimum_jerk_trajectory.sv
`timescale 1ns / 1ps
// Minimum-jerk quintic trajectory generator.
// req channel: one transaction carries start and end position, velocity and
// acceleration (signed Q16.16). rsp channel: N transactions follow, one per
// sample k = 1..N, with the position at t = k * time_step, the index k and a
// flag on the last one. N is step_count clamped to 1..64.
// csr port: index 0 step_count, index 1 time_step; write only while idle.
// Coefficient setup comes first; each sample is then issued and passes 5
// Horner stages, rounding, range check and a 32-stage restoring divider.
// Samples leave one per cycle unless rsp_ready stalls them, and the sample
// generator loads the next run once its Horner stages drain. The next
// request is taken while a run is still in flight.
// Reset clears all valid bits and restores step_count 50, time_step 1311.
// With a sample waiting and rsp_ready low, the whole sample pipeline holds;
// nothing is lost or repeated; req_ready drops once setup backs up behind it.
module minimum_jerk_trajectory (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mjt_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mjt_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [mjt_pkg::CSR_W-1:0] csr_wdata
);

   logic [mjt_pkg::CNT_W-1:0] step_count_ff;
   logic [mjt_pkg::TS_W-1:0]  time_step_ff;
   logic [mjt_pkg::CNT_W-1:0] count_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= mjt_pkg::STEP_COUNT_RESET;
         time_step_ff  <= mjt_pkg::TIME_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mjt_pkg::CSR_STEP_COUNT: step_count_ff <= csr_wdata[mjt_pkg::CNT_W-1:0];
            mjt_pkg::CSR_TIME_STEP:  time_step_ff  <= csr_wdata[mjt_pkg::TS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (step_count_ff == '0) begin
         count_c = mjt_pkg::CNT_W'(1);
      end else if (step_count_ff > mjt_pkg::CNT_W'(mjt_pkg::MAX_STEPS)) begin
         count_c = mjt_pkg::CNT_W'(mjt_pkg::MAX_STEPS);
      end else begin
         count_c = step_count_ff;
      end
   end

   logic              coef_valid, coef_ready;
   mjt_pkg::coef_type coef;

   mjt_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .count     (count_c),
      .tstep     (time_step_ff),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .out_data  (coef)
   );

   mjt_sample u_sample (
      .clock      (clock),
      .reset      (reset),
      .coef_valid (coef_valid),
      .coef_ready (coef_ready),
      .coef       (coef),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### src/mjt_checker.sv
`timescale 1ns / 1ps
`include "minimum_jerk_trajectory_macros.svh"

module mjt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mjt_pkg::rsp_type rsp_data
);

   `MJT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `MJT_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_sample, !rsp_valid || rsp_data.sample_index == $past(rsp_data.sample_index) + 7'd1)

   `MJT_ASSERT_NEXT(a_run_restart, clock, reset, rsp_valid && rsp_ready && rsp_data.last_sample, !rsp_valid || rsp_data.sample_index == 7'd1)

   `MJT_ASSERT_PLAIN(a_reset_empty, clock, $past(reset), !rsp_valid && req_ready)

endmodule

bind minimum_jerk_trajectory mjt_checker u_mjt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### dv/minimum_jerk_trajectory_tb.sv
`timescale 1ns / 1ps

module minimum_jerk_trajectory_tb;

   typedef logic signed [127:0] w128_type;

   class scoreboard_type;
      mjt_pkg::rsp_type samples_due[$];
      int      step_count = 50;
      int      time_step = 1311;
      int      errors = 0;
      int      runs_seen = 0;
      int      samples_seen = 0;

      // Exact quintic evaluation with 128-bit integers, rounded half up.
      function void note_run(mjt_pkg::req_type r);
         w128_type k0, k1, k2, l0, l1, l2, b0x2, b1, b2, acc, np, q, tr;
         w128_type c[6];
         int n;
         mjt_pkg::rsp_type s;
         n = step_count;
         if (n < 1) n = 1;
         if (n > mjt_pkg::MAX_STEPS) n = mjt_pkg::MAX_STEPS;
         tr = n * time_step;
         k0 = r.start_position;
         k1 = r.start_velocity;
         k2 = r.start_accel;
         l0 = r.end_position;
         l1 = r.end_velocity;
         l2 = r.end_accel;
         k0 = k0 <<< 32;
         l0 = l0 <<< 32;
         k1 = (k1 * tr) <<< 16;
         l1 = (l1 * tr) <<< 16;
         k2 = k2 * tr * tr;
         l2 = l2 * tr * tr;
         b0x2 = (l0 <<< 1) - (k0 <<< 1) - (k1 <<< 1) - k2;
         b1 = l1 - k1 - k2;
         b2 = l2 - k2;
         c[0] = k0 <<< 1;
         c[1] = k1 <<< 1;
         c[2] = k2;
         c[3] = b0x2 * 10 - b1 * 8 + b2;
         c[4] = b1 * 14 - b0x2 * 15 - b2 * 2;
         c[5] = b0x2 * 6 - b1 * 6 + b2;
         for (int k = 1; k <= n; k++) begin
            acc = c[5];
            np = 1;
            for (int i = 4; i >= 0; i--) begin
               np = np * n;
               acc = acc * k + c[i] * np;
            end
            acc = acc + (np <<< 32);
            acc = acc >>> 33;
            q = acc / np;
            // floor toward minus infinity
            if (acc < 0 && q * np != acc) q = q - 1;
            if (q > 64'sd2147483647) s.sample_value = mjt_pkg::SAT_HI;
            else if (q < -64'sd2147483648) s.sample_value = mjt_pkg::SAT_LO;
            else s.sample_value = q[31:0];
            s.sample_index = k[mjt_pkg::CNT_W-1:0];
            s.last_sample = (k == n);
            samples_due = {samples_due, s};
         end
         runs_seen++;
      endfunction

      function void check_sample(mjt_pkg::rsp_type got);
         mjt_pkg::rsp_type want;
         samples_seen++;
         if (samples_due.size() == 0) begin
            $display("%0t: unexpected sample transaction %p", $time, got);
            errors++;
            return;
         end
         want = samples_due.pop_front();
         if (got.sample_value !== want.sample_value) begin
            $display("%0t: sample_value expected %0d actual %0d", $time,
                     want.sample_value, got.sample_value);
            errors++;
         end
         if (got.sample_index !== want.sample_index) begin
            $display("%0t: sample_index expected %0d actual %0d", $time,
                     want.sample_index, got.sample_index);
            errors++;
         end
         if (got.last_sample !== want.last_sample) begin
            $display("%0t: last_sample expected %0b actual %0b", $time,
                     want.last_sample, got.last_sample);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   mjt_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   mjt_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [0:0] csr_index;
   logic [mjt_pkg::CSR_W-1:0] csr_wdata;

   scoreboard_type sb = new();
   bit no_stall = 0;
   int settings_used = 0;

   minimum_jerk_trajectory dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("minimum_jerk_trajectory_tb NOT OK");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_stall || roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sample consumer with random back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_sample(rsp_data);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            hold = pick_gap();
         end
      end
   end

   task automatic send_run(mjt_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_run(r);
   endtask

   task automatic set_timing(int count, int step);
      req_valid <= 0;
      wait (sb.samples_due.size() == 0);
      repeat (60) @(posedge clock);
      csr_we <= 1;
      csr_index <= mjt_pkg::CSR_STEP_COUNT;
      csr_wdata <= mjt_pkg::CSR_W'(count);
      @(posedge clock);
      csr_index <= mjt_pkg::CSR_TIME_STEP;
      csr_wdata <= mjt_pkg::CSR_W'(step);
      @(posedge clock);
      csr_we <= 0;
      sb.step_count = count & 'h7F;
      sb.time_step = step & 'hFFFF;
      settings_used++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 6))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 0;
         4: return $urandom() >>> $urandom_range(8, 31);
         default: return $signed($urandom_range(0, 'h40000)) - 'sh20000;
      endcase
   endfunction

   function automatic mjt_pkg::req_type rand_run();
      mjt_pkg::req_type r;
      r.start_position = rand_word();
      r.start_velocity = rand_word();
      r.start_accel = rand_word();
      r.end_position = rand_word();
      r.end_velocity = rand_word();
      r.end_accel = rand_word();
      return r;
   endfunction

   function automatic mjt_pkg::req_type all_fields(logic [31:0] a, logic [31:0] b);
      mjt_pkg::req_type r;
      r = {a, a, a, b, b, b};
      return r;
   endfunction

   initial begin
      int count, step;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = mjt_pkg::CSR_STEP_COUNT;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset timing, then the boundary settings
      send_run(all_fields(32'h0, 32'h0001_0000));
      send_run(all_fields(32'h7FFF_FFFF, 32'h8000_0000));
      send_run(all_fields(32'h8000_0000, 32'h7FFF_FFFF));
      set_timing(0, 0);
      send_run(all_fields(32'h1234_5678, 32'h8765_4321));
      set_timing(1, 65535);
      send_run(all_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_run(all_fields(32'hFFFF_FFFF, 32'h0000_0001));
      set_timing(64, 65535);
      send_run(all_fields(32'h8000_0000, 32'h8000_0000));
      send_run(all_fields(32'h0, 32'h0));
      send_run({32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
      set_timing(127, 1);
      send_run(all_fields(32'h0100_0000, 32'hFF00_0000));
      set_timing(100, 0);
      send_run(all_fields(32'h8000_0000, 32'h7FFF_FFFF));
      send_run(rand_run());
      set_timing(7, 300);
      for (int i = 0; i < 4; i++) send_run(rand_run());

      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 4))
            0: count = $urandom_range(0, 127);
            1: count = $urandom_range(60, 64);
            default: count = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 3))
            0: step = $urandom_range(0, 65535);
            1: step = $urandom_range(0, 3) == 0 ? 0 : 65535;
            default: step = $urandom_range(1, 4000);
         endcase
         set_timing(count, step);
         no_stall = (p % 3 == 2);
         for (int i = 0; i < 36; i++) send_run(rand_run());
      end
      req_valid <= 0;

      wait (sb.samples_due.size() == 0);
      repeat (60) @(posedge clock);
      $display("covered %0d runs, %0d samples, %0d timing settings",
               sb.runs_seen, sb.samples_seen, settings_used);
      if (sb.errors == 0) $display("minimum_jerk_trajectory_tb OK");
      else $display("minimum_jerk_trajectory_tb NOT OK");
      $finish;
   end
endmodule

### filelist.f
+incdir+src
src/mjt_pkg.sv
src/mjt_coef.sv
src/mjt_sample.sv
src/minimum_jerk_trajectory.sv
src/mjt_checker.sv
dv/minimum_jerk_trajectory_tb.sv
